>>> rtl/echoing_line_editor_defines.svh
// Assertion macros used by the line editor core.
`ifndef ECHOING_LINE_EDITOR_DEFINES_SVH
`define ECHOING_LINE_EDITOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define ELE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line editor check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ELE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line editor check failed");

`else

`define ELE_ASSERT_IMP(lbl, ante, cons)
`define ELE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/ele_pkg.sv
// Shared types and character constants of the line editor.
`default_nettype none

package ele_pkg;

  // Request kinds
  localparam logic ReqRecv = 1'b0;
  localparam logic ReqRead = 1'b1;

  // Control characters
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChNul = 8'h00;

  // Room kept for line feed and terminating zero
  localparam int TermRoom = 2;

  localparam logic [6:0] CapReset = 7'd80;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
    logic [6:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       is_echo;
    logic       line_done;
    logic [6:0] line_length;
    logic       last;
  } result_t;

  // One store write; slot may point past the buffer and is then dropped
  typedef struct packed {
    logic       en;
    logic [7:0] slot;
    logic [7:0] data;
  } store_wr_t;

endpackage

`default_nettype wire

>>> rtl/echoing_line_editor.sv
// Echoing line editor: input register, core with line store, output register.
//
// Usage:
//   in_*  : requests. in_tuser = 0 receives a character (in_tdata[7:0]),
//           in_tuser = 1 reads line slot in_tdata[14:8].
//   out_* : results, one per cycle while out_tready is high. out_tuser = 1
//           marks an echo byte, 0 read data; out_tlast closes a request's results.
//   cfg_* : writes line_capacity (always ready; write only while idle).
//   First result of a request is valid after the input register, sequencer
//   and output register. A read or an ordinary character gives one result,
//   a backspace or a character that ends the line three, set by the single
//   result register draining one result per cycle while out_tready is high.
//   A receive after a finished line starts a new line at slot 0.
//   Reset clears line position, done flag and sets capacity to 80; buffer
//   contents stay undefined until written, no clearing pass.
//   When out_tready is low the output register holds and the core and input
//   register fill; in_tready then drops until results drain.
`default_nettype none

module echoing_line_editor import ele_pkg::*; #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_char, [14:8] read_index, [15] zero
  input  logic        in_tuser,   // [0] req_type
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] tx_byte, [8] line_done, [15:9] line_length
  output logic        out_tuser,  // [0] is_echo
  output logic        out_tlast,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic [6:0] cap_r;
  logic       a_valid_r;
  in_item_t   a_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       take;
  logic       emit;
  logic       out_free;
  result_t    res;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Input register
  assign in_tready = !a_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      a_valid_r <= 1'b1;
    end else if (take) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_item_r.req_type   <= in_tuser;
      a_item_r.rx_char    <= in_tdata[7:0];
      a_item_r.read_index <= in_tdata[14:8];
    end
  end

  ele_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .line_capacity (cap_r),
    .a_valid       (a_valid_r),
    .a_item        (a_item_r),
    .take          (take),
    .out_free      (out_free),
    .emit          (emit),
    .res           (res)
  );

  // Output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.line_length, out_res_r.line_done, out_res_r.tx_byte};
  assign out_tuser  = out_res_r.is_echo;
  assign out_tlast  = out_res_r.last;

endmodule

`default_nettype wire

>>> rtl/ele_line_store.sv
// Line buffer memory: one write port, one registered read port with write bypass.
`default_nettype none

module ele_line_store import ele_pkg::*; #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  store_wr_t  wr,
  input  logic       rd_en,
  input  logic [6:0] rd_idx,
  output logic [7:0] rd_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_q_r;
  logic [7:0] byp_data_r;
  logic       byp_r;
  logic       rd_ok_r;
  logic       wr_ok;
  logic       rd_ok;
  logic       hit;

  // Drop writes that fall outside the buffer; reads outside it return zero
  assign wr_ok = wr.en && (32'(wr.slot) < BUFFER_DEPTH);
  assign rd_ok = 32'(rd_idx) < BUFFER_DEPTH;
  assign hit   = wr_ok && (wr.slot == {1'b0, rd_idx});

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[AW'(wr.slot)] <= wr.data;
    end
  end

  // Register read data; forward a write to the same slot in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[AW'(rd_idx)];
      byp_r      <= hit;
      byp_data_r <= wr.data;
      rd_ok_r    <= rd_ok;
    end
  end

  assign rd_data = !rd_ok_r ? ChNul : (byp_r ? byp_data_r : rd_q_r);

endmodule

`default_nettype wire

>>> rtl/ele_core.sv
// Line editor core: decodes a request, updates line state, sequences its results.
`default_nettype none

`include "echoing_line_editor_defines.svh"

module ele_core import ele_pkg::*; #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [6:0] line_capacity,
  input  logic       a_valid,
  input  in_item_t   a_item,
  output logic       take,
  input  logic       out_free,
  output logic       emit,
  output result_t    res
);

  localparam int EffMax = BUFFER_DEPTH - 1;
  localparam int CW     = ($clog2(BUFFER_DEPTH) > 7) ? $clog2(BUFFER_DEPTH) + 1 : 8;

  // Line state
  logic [6:0] wp_r;
  logic       done_r;

  // Request in progress
  logic       e_valid_r;
  logic [1:0] e_step_r;
  logic [1:0] e_lastidx_r;
  logic       e_rd_r;
  logic       e_done_r;
  logic [6:0] e_len_r;
  logic [7:0] e_byte_r  [3];
  logic       e_wen_r   [3];
  logic [7:0] e_wslot_r [3];
  logic [7:0] e_wdat_r  [3];
  logic       e_last;

  // Decode of the waiting request
  logic [6:0]    d_wp0;
  logic [6:0]    d_wp1;
  logic [CW-1:0] d_cap;
  logic [CW-1:0] d_eff;
  logic          d_term;
  logic [1:0]    d_lastidx;
  logic          d_rd;
  logic [6:0]    d_wp;
  logic          d_done;
  logic [7:0]    d_byte  [3];
  logic          d_wen   [3];
  logic [7:0]    d_wslot [3];
  logic [7:0]    d_wdat  [3];

  store_wr_t  wr;
  logic [7:0] rd_data;

  // Handshake between waiting request, sequencer and output register
  assign e_last = (e_step_r == e_lastidx_r);
  assign emit   = e_valid_r && out_free;
  assign take   = a_valid && (!e_valid_r || (emit && e_last));

  // Work out results, store writes and next state for the waiting request
  always_comb begin
    d_wp0     = done_r ? 7'd0 : wp_r;
    d_wp1     = d_wp0 + 7'd1;
    d_cap     = CW'(line_capacity);
    d_eff     = (d_cap < CW'(EffMax)) ? d_cap : CW'(EffMax);
    d_term    = (a_item.rx_char == ChCr) || ((CW'(d_wp1) + CW'(TermRoom)) > d_eff);
    d_lastidx = 2'd0;
    d_rd      = 1'b0;
    d_wp      = wp_r;
    d_done    = done_r;
    d_byte    = '{a_item.rx_char, ChSp, ChBs};
    d_wen     = '{1'b0, 1'b0, 1'b0};
    d_wslot   = '{{1'b0, d_wp0}, {1'b0, d_wp1}, {1'b0, d_wp1} + 8'd1};
    d_wdat    = '{a_item.rx_char, ChLf, ChNul};
    if (a_item.req_type == ReqRead) begin
      d_rd = 1'b1;
    end else if (a_item.rx_char == ChBs) begin
      d_lastidx = 2'd2;
      d_wen[0]  = 1'b1;
      d_wdat[0] = ChNul;
      d_wp      = (d_wp0 != 7'd0) ? d_wp0 - 7'd1 : 7'd0;
      d_done    = 1'b0;
    end else begin
      d_wen[0] = 1'b1;
      d_wp     = d_wp1;
      d_done   = d_term;
      if (d_term) begin
        d_lastidx = 2'd2;
        d_wen[1]  = 1'b1;
        d_wen[2]  = 1'b1;
        d_byte[1] = ChLf;
        d_byte[2] = ChCr;
      end
    end
  end

  // Commit line state when a request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 7'd0;
      done_r <= 1'b0;
    end else if (take) begin
      wp_r   <= d_wp;
      done_r <= d_done;
    end
  end

  // Sequencer control: hold a request until its last result leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      e_step_r  <= 2'd0;
    end else if (take) begin
      e_valid_r <= 1'b1;
      e_step_r  <= 2'd0;
    end else if (emit) begin
      if (e_last) begin
        e_valid_r <= 1'b0;
      end else begin
        e_step_r <= e_step_r + 2'd1;
      end
    end
  end

  // Sequencer payload
  always_ff @(posedge clk) begin
    if (take) begin
      e_lastidx_r <= d_lastidx;
      e_rd_r      <= d_rd;
      e_done_r    <= d_done;
      e_len_r     <= d_wp;
      e_byte_r    <= d_byte;
      e_wen_r     <= d_wen;
      e_wslot_r   <= d_wslot;
      e_wdat_r    <= d_wdat;
    end
  end

  // At most one store write per result step
  assign wr.en   = emit && e_wen_r[e_step_r];
  assign wr.slot = e_wslot_r[e_step_r];
  assign wr.data = e_wdat_r[e_step_r];

  ele_line_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (take),
    .rd_idx  (a_item.read_index),
    .rd_data (rd_data)
  );

  // Current result
  assign res.tx_byte     = e_rd_r ? rd_data : e_byte_r[e_step_r];
  assign res.is_echo     = !e_rd_r;
  assign res.line_done   = e_done_r;
  assign res.line_length = e_len_r;
  assign res.last        = e_last;

  `ELE_ASSERT_IMP(a_step_bound, e_valid_r, e_step_r <= e_lastidx_r)
  `ELE_ASSERT_IMP(a_read_single, e_valid_r && e_rd_r, e_lastidx_r == 2'd0)
  `ELE_ASSERT_NXT(a_hold_request, emit && !e_last, e_valid_r && (e_step_r != 2'd0))

endmodule

`default_nettype wire
